### rtl/ethhp_pkg.sv
package ethhp_pkg;

  localparam int POS_W      = 17;
  localparam int N_W        = POS_W + 1;
  localparam int NUM_PREFIX = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ETHERTYPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL  = 1'd1;

  localparam logic [15:0] ETHERTYPE_RESET = 16'h0800;
  localparam logic [7:0]  PROTOCOL_RESET  = 8'd6;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_NOT_IPV4  = 3'd1,
    ST_NOT_TCP   = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [5:0]  ip_hdr_bytes;
    logic [5:0]  tcp_hdr_bytes;
    logic [15:0] payload_bytes;
    logic        http_message;
  } out_item_t;

  // Prefix text, left aligned, first character in the top byte
  function automatic logic [7:0] prefix_char(input logic [2:0] idx, input logic [2:0] k);
    logic [63:0] word;
    case (idx)
      3'd0:    word = {"GET ", 32'h0};
      3'd1:    word = {"POST ", 24'h0};
      3'd2:    word = {"HEAD ", 24'h0};
      3'd3:    word = {"PUT ", 32'h0};
      3'd4:    word = {"DELETE ", 8'h0};
      3'd5:    word = "OPTIONS ";
      3'd6:    word = {"HTTP/", 24'h0};
      default: word = 64'h0;
    endcase
    return word[{~k, 3'b000} +: 8];
  endfunction

  function automatic logic [3:0] prefix_len(input logic [2:0] idx);
    logic [3:0] len;
    case (idx)
      3'd0:    len = 4'd4;
      3'd1:    len = 4'd5;
      3'd2:    len = 4'd5;
      3'd3:    len = 4'd4;
      3'd4:    len = 4'd7;
      3'd5:    len = 4'd8;
      3'd6:    len = 4'd5;
      default: len = 4'd8;
    endcase
    return len;
  endfunction

endpackage

### rtl/eth_ipv4_tcp_http_header_parser_unit.sv
// A frame's result enters a result slot when its last byte transfers. Throughput: one byte
// per cycle while in_stall is low; the capture registers update on every input transfer.
// Two result slots (output register plus skid register) let input continue while a
// result waits; in_stall rises only when both slots hold results.
// Reset (rst_n, synchronous, active low) clears all frame state and both result slots,
// and loads ethertype 0x0800 and protocol 6 into the match registers.
module eth_ipv4_tcp_http_header_parser_unit
  import ethhp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic      in_xfer;
  logic      out_xfer;
  logic      res_valid;
  out_item_t res;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      skid_valid_r;
  out_item_t skid_data_r;

  // Stall input only when the skid slot is occupied; no combinational path from out_stall
  assign in_stall  = skid_valid_r;
  assign in_xfer   = in_valid && !in_stall;
  assign res_valid = in_xfer && in_data.last_byte;
  assign out_xfer  = out_valid_r && !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Byte-position capture and frame verdict
  ethhp_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_xfer),
    .item      (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  // Output register with a skid slot behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_xfer || !out_valid_r) begin
      // Output slot frees up: advance the skid entry first, else the new result
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
        if (res_valid) begin
          out_data_r <= res;
        end
      end
    end else if (res_valid) begin
      // Output held by the consumer: park the new result
      skid_valid_r <= 1'b1;
      skid_data_r  <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full while output slot empty");

  a_result_presented: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_valid_r)
    else $error("last byte transfer did not produce a pending result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.status <= ST_TRUNCATED)
    else $error("result status outside the defined codes");

  a_http_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.http_message) |->
      (out_data_r.status == ST_ACCEPTED && out_data_r.payload_bytes >= 16'd4))
    else $error("http flag set on a frame that cannot hold a prefix");

endmodule

### rtl/ethhp_capture.sv
module ethhp_capture
  import ethhp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  in_item_t              item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output out_item_t             res
);

  localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] TCP_EARLIEST = POS_W'(34);

  logic [15:0]           ethertype_cfg_r;
  logic [7:0]            protocol_cfg_r;

  logic [POS_W-1:0]      pos_r;
  logic [47:0]           dmac_r, dmac_nxt;
  logic [47:0]           smac_r, smac_nxt;
  logic [15:0]           etype_r, etype_nxt;
  logic [3:0]            ihl_r, ihl_nxt;
  logic [15:0]           iplen_r, iplen_nxt;
  logic [7:0]            proto_r, proto_nxt;
  logic [31:0]           sip_r, sip_nxt;
  logic [31:0]           dip_r, dip_nxt;
  logic [3:0]            doff_r, doff_nxt;
  logic [15:0]           sport_r, sport_nxt;
  logic [15:0]           dport_r, dport_nxt;
  logic [NUM_PREFIX-1:0] cand_r, cand_nxt;
  logic [POS_W-1:0]      pos_nxt;

  logic [7:0]            b;
  logic [6:0]            t_cur;
  logic [POS_W-1:0]      t_pos;
  logic [7:0]            p_cur;
  logic [POS_W-1:0]      p_pos;
  logic [POS_W-1:0]      k_diff;

  logic [5:0]            ip_b, tcp_b;
  logic [6:0]            t_n;
  logic [7:0]            p_n;
  logic [N_W-1:0]        n;
  logic [N_W-1:0]        avail;
  logic [17:0]           pay;
  logic [15:0]           pay_out;
  logic                  http;

  assign b = item.data_byte;

  // Field capture for the current byte, selected by its position
  always_comb begin
    dmac_nxt  = dmac_r;
    smac_nxt  = smac_r;
    etype_nxt = etype_r;
    ihl_nxt   = ihl_r;
    iplen_nxt = iplen_r;
    proto_nxt = proto_r;
    sip_nxt   = sip_r;
    dip_nxt   = dip_r;
    doff_nxt  = doff_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    cand_nxt  = cand_r;

    t_cur  = 7'd14 + {1'b0, ihl_r, 2'b00};
    t_pos  = POS_W'(t_cur);
    p_cur  = {1'b0, t_cur} + {2'b00, doff_r, 2'b00};
    p_pos  = POS_W'(p_cur);
    k_diff = pos_r - p_pos;

    if (pos_r < POS_W'(6)) begin
      dmac_nxt = {dmac_r[39:0], b};
    end else if (pos_r < POS_W'(12)) begin
      smac_nxt = {smac_r[39:0], b};
    end else if (pos_r < POS_W'(14)) begin
      etype_nxt = {etype_r[7:0], b};
    end else if (pos_r == POS_W'(14)) begin
      ihl_nxt = b[3:0];
    end else if (pos_r == POS_W'(16) || pos_r == POS_W'(17)) begin
      iplen_nxt = {iplen_r[7:0], b};
    end else if (pos_r == POS_W'(23)) begin
      proto_nxt = b;
    end else if (pos_r >= POS_W'(26) && pos_r < POS_W'(30)) begin
      sip_nxt = {sip_r[23:0], b};
    end else if (pos_r >= POS_W'(30) && pos_r < TCP_EARLIEST) begin
      dip_nxt = {dip_r[23:0], b};
    end

    if (pos_r >= TCP_EARLIEST) begin
      if (pos_r == t_pos || pos_r == t_pos + POS_W'(1)) begin
        sport_nxt = {sport_r[7:0], b};
      end else if (pos_r == t_pos + POS_W'(2) || pos_r == t_pos + POS_W'(3)) begin
        dport_nxt = {dport_r[7:0], b};
      end else if (pos_r == t_pos + POS_W'(12)) begin
        doff_nxt = b[7:4];
      end
      // Drop prefixes that disagree within the first eight payload bytes
      if (pos_r > t_pos + POS_W'(12) && pos_r >= p_pos && k_diff < POS_W'(8)) begin
        for (int i = 0; i < NUM_PREFIX; i++) begin
          if ({1'b0, k_diff[2:0]} < prefix_len(3'(i)) &&
              b != prefix_char(3'(i), k_diff[2:0])) begin
            cand_nxt[i] = 1'b0;
          end
        end
      end
    end

    pos_nxt = (pos_r < POS_MAX) ? pos_r + POS_W'(1) : pos_r;
  end

  // Frame verdict, taken from the stores as updated by the final byte
  always_comb begin
    ip_b    = {ihl_nxt, 2'b00};
    tcp_b   = {doff_nxt, 2'b00};
    t_n     = 7'd14 + {1'b0, ip_b};
    p_n     = {1'b0, t_n} + {2'b00, tcp_b};
    n       = {1'b0, pos_r} + N_W'(1);
    avail   = n - N_W'(p_n);
    pay     = {2'b00, iplen_nxt} - 18'(ip_b) - 18'(tcp_b);
    pay_out = 16'h0;
    http    = 1'b0;

    res = '0;
    if (n < N_W'(14)) begin
      res.status = ST_TRUNCATED;
    end else if (etype_nxt != ethertype_cfg_r) begin
      res.status = ST_NOT_IPV4;
    end else if (n < N_W'(24)) begin
      res.status = ST_TRUNCATED;
    end else if (proto_nxt != protocol_cfg_r) begin
      res.status = ST_NOT_TCP;
    end else if (ip_b < 6'd20) begin
      res.status = ST_MALFORMED;
    end else if (n < N_W'(t_n) + N_W'(13)) begin
      res.status = ST_TRUNCATED;
    end else if (tcp_b < 6'd20) begin
      res.status = ST_MALFORMED;
    end else if (pay[17]) begin
      res.status = ST_MALFORMED;
    end else if (n < N_W'(p_n)) begin
      res.status = ST_TRUNCATED;
    end else begin
      res.status = ST_ACCEPTED;
      pay_out    = pay[15:0];
      for (int i = 0; i < NUM_PREFIX; i++) begin
        if (cand_nxt[i] && 16'(prefix_len(3'(i))) <= pay_out &&
            N_W'(prefix_len(3'(i))) <= avail) begin
          http = 1'b1;
        end
      end
    end

    res.dest_mac      = dmac_nxt;
    res.source_mac    = smac_nxt;
    res.source_ip     = sip_nxt;
    res.dest_ip       = dip_nxt;
    res.source_port   = sport_nxt;
    res.dest_port     = dport_nxt;
    res.ip_hdr_bytes  = ip_b;
    res.tcp_hdr_bytes = tcp_b;
    res.payload_bytes = pay_out;
    res.http_message  = http;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ethertype_cfg_r <= ETHERTYPE_RESET;
      protocol_cfg_r  <= PROTOCOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ETHERTYPE: ethertype_cfg_r <= cfg_wdata;
        CFG_PROTOCOL:  protocol_cfg_r  <= cfg_wdata[7:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && item.last_byte)) begin
      pos_r   <= '0;
      dmac_r  <= '0;
      smac_r  <= '0;
      etype_r <= '0;
      ihl_r   <= '0;
      iplen_r <= '0;
      proto_r <= '0;
      sip_r   <= '0;
      dip_r   <= '0;
      doff_r  <= '0;
      sport_r <= '0;
      dport_r <= '0;
      cand_r  <= '1;
    end else if (take) begin
      pos_r   <= pos_nxt;
      dmac_r  <= dmac_nxt;
      smac_r  <= smac_nxt;
      etype_r <= etype_nxt;
      ihl_r   <= ihl_nxt;
      iplen_r <= iplen_nxt;
      proto_r <= proto_nxt;
      sip_r   <= sip_nxt;
      dip_r   <= dip_nxt;
      doff_r  <= doff_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
      cand_r  <= cand_nxt;
    end
  end

endmodule

### bench/eth_ipv4_tcp_http_header_parser_unit_tb.sv
`timescale 1ns / 1ps

module eth_ipv4_tcp_http_header_parser_unit_tb;
  import ethhp_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung
  localparam int QUIET_LIMIT   = 3000;
  // Length of the long receiver hold-off, in cycles
  localparam int HOLD_CYCLES   = 300;
  // Cycles to let pass after the last result before touching the registers
  localparam int SETTLE_CYCLES = 4;
  // Byte position saturates here
  localparam int POS_LIMIT     = (1 << POS_W) - 1;

  // Payload prefix selectors for the frame builder; 0..6 pick a real prefix
  localparam int PFX_GET       = 0;
  localparam int PFX_OPTIONS   = 5;
  localparam int PFX_HTTP      = 6;
  localparam int PFX_NEAR_MISS = 7;
  localparam int PFX_NONE      = 8;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ETHERTYPE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  eth_ipv4_tcp_http_header_parser_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Header predictor: a private copy of the frame state and the match registers.
  // It advances once per accepted input transfer and queues one header summary
  // whenever a frame closes.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] cur_pos;
  logic [47:0]      cur_dst_mac;
  logic [47:0]      cur_src_mac;
  logic [15:0]      cur_etype;
  logic [3:0]       cur_ihl;
  logic [15:0]      cur_total_len;
  logic [7:0]       cur_proto;
  logic [31:0]      cur_src_ip;
  logic [31:0]      cur_dst_ip;
  logic [3:0]       cur_doff;
  logic [15:0]      cur_src_port;
  logic [15:0]      cur_dst_port;
  logic [NUM_PREFIX-1:0] cur_cands;
  logic [15:0]      match_ethertype_q = ETHERTYPE_RESET;
  logic [7:0]       match_protocol_q  = PROTOCOL_RESET;

  // Header summaries predicted but not yet seen on the result channel
  out_item_t header_results_due[$];
  // Frame under construction by the stimulus side
  logic [7:0] frame_bytes[$];

  int  mismatch_count = 0;
  int  bytes_accepted = 0;
  int  frames_closed  = 0;
  int  quiet_cycles   = 0;
  bit  idle_enable    = 1'b1;
  bit  hold_request   = 1'b0;

  function automatic string http_prefix(input int idx);
    case (idx)
      0:       return "GET ";
      1:       return "POST ";
      2:       return "HEAD ";
      3:       return "PUT ";
      4:       return "DELETE ";
      5:       return "OPTIONS ";
      default: return "HTTP/";
    endcase
  endfunction

  function automatic void clear_frame();
    cur_pos       = '0;
    cur_dst_mac   = '0;
    cur_src_mac   = '0;
    cur_etype     = '0;
    cur_ihl       = '0;
    cur_total_len = '0;
    cur_proto     = '0;
    cur_src_ip    = '0;
    cur_dst_ip    = '0;
    cur_doff      = '0;
    cur_src_port  = '0;
    cur_dst_port  = '0;
    cur_cands     = '1;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic lst);
    int        pos, tcp_at, pay_at, k, n, ip_len, tcp_len, pay, pay_out;
    logic      http;
    string     pfx;
    status_t   st;
    out_item_t res;
    pos = cur_pos;
    if (pos < 6) cur_dst_mac = {cur_dst_mac[39:0], b};
    else if (pos < 12) cur_src_mac = {cur_src_mac[39:0], b};
    else if (pos < 14) cur_etype = {cur_etype[7:0], b};
    else if (pos == 14) cur_ihl = b[3:0];
    else if (pos == 16 || pos == 17) cur_total_len = {cur_total_len[7:0], b};
    else if (pos == 23) cur_proto = b;
    else if (pos >= 26 && pos < 30) cur_src_ip = {cur_src_ip[23:0], b};
    else if (pos >= 30 && pos < 34) cur_dst_ip = {cur_dst_ip[23:0], b};

    // TCP fields are never taken ahead of byte 34, whatever the IP header says
    if (pos >= 34) begin
      tcp_at = 14 + 4 * cur_ihl;
      if (pos == tcp_at || pos == tcp_at + 1) cur_src_port = {cur_src_port[7:0], b};
      else if (pos == tcp_at + 2 || pos == tcp_at + 3) cur_dst_port = {cur_dst_port[7:0], b};
      else if (pos == tcp_at + 12) cur_doff = b[7:4];
      if (pos > tcp_at + 12) begin
        pay_at = tcp_at + 4 * cur_doff;
        if (pos >= pay_at && pos - pay_at < 8) begin
          k = pos - pay_at;
          for (int i = 0; i < NUM_PREFIX; i++) begin
            pfx = http_prefix(i);
            if (k < pfx.len() && b != pfx[k]) cur_cands[i] = 1'b0;
          end
        end
      end
    end

    if (pos < POS_LIMIT) cur_pos = cur_pos + 1'b1;
    if (!lst) return;

    frames_closed++;
    n       = pos + 1;
    ip_len  = 4 * cur_ihl;
    tcp_len = 4 * cur_doff;
    tcp_at  = 14 + ip_len;
    pay_at  = tcp_at + tcp_len;
    pay     = cur_total_len;
    pay     = pay - ip_len - tcp_len;
    pay_out = 0;
    http    = 1'b0;

    if (n < 14) st = ST_TRUNCATED;
    else if (cur_etype != match_ethertype_q) st = ST_NOT_IPV4;
    else if (n < 24) st = ST_TRUNCATED;
    else if (cur_proto != match_protocol_q) st = ST_NOT_TCP;
    else if (ip_len < 20) st = ST_MALFORMED;
    else if (n < tcp_at + 13) st = ST_TRUNCATED;
    else if (tcp_len < 20) st = ST_MALFORMED;
    else if (pay < 0) st = ST_MALFORMED;
    else if (n < pay_at) st = ST_TRUNCATED;
    else begin
      st      = ST_ACCEPTED;
      pay_out = pay;
      // A prefix counts only when it fits in both the payload and the capture
      for (int i = 0; i < NUM_PREFIX; i++) begin
        pfx = http_prefix(i);
        if (cur_cands[i] && pfx.len() <= pay_out && pfx.len() <= n - pay_at) http = 1'b1;
      end
    end

    res.status        = st;
    res.dest_mac      = cur_dst_mac;
    res.source_mac    = cur_src_mac;
    res.source_ip     = cur_src_ip;
    res.dest_ip       = cur_dst_ip;
    res.source_port   = cur_src_port;
    res.dest_port     = cur_dst_port;
    res.ip_hdr_bytes  = ip_len[5:0];
    res.tcp_hdr_bytes = tcp_len[5:0];
    res.payload_bytes = pay_out[15:0];
    res.http_message  = http;
    header_results_due.push_back(res);
    clear_frame();
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every result transfer is matched against the oldest
  // predicted header summary, field by field.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [47:0] got, input logic [47:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (header_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result transfer with nothing predicted: %0h", $time, out_data);
      end else begin
        want = header_results_due.pop_front();
        check_field("status",        out_data.status,        want.status);
        check_field("dest_mac",      out_data.dest_mac,      want.dest_mac);
        check_field("source_mac",    out_data.source_mac,    want.source_mac);
        check_field("source_ip",     out_data.source_ip,     want.source_ip);
        check_field("dest_ip",       out_data.dest_ip,       want.dest_ip);
        check_field("source_port",   out_data.source_port,   want.source_port);
        check_field("dest_port",     out_data.dest_port,     want.dest_port);
        check_field("ip_hdr_bytes",  out_data.ip_hdr_bytes,  want.ip_hdr_bytes);
        check_field("tcp_hdr_bytes", out_data.tcp_hdr_bytes, want.tcp_hdr_bytes);
        check_field("payload_bytes", out_data.payload_bytes, want.payload_bytes);
        check_field("http_message",  out_data.http_message,  want.http_message);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[eth_ipv4_tcp_http_header_parser_unit] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request, and a clean
  // always-ready stretch once idling is switched off.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_request = 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one byte and hold it until it transfers; update the predictor then.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (idle_enable && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: lst};
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_accepted++;
    parse_byte(b, lst);
  endtask

  task automatic send_frame(input bit close);
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], close && i == frame_bytes.size() - 1);
  endtask

  // Drop valid and hold until every predicted summary has been checked,
  // then let the block settle before anything touches the registers.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (header_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void put_byte(input int pos, input logic [7:0] v);
    if (pos < frame_bytes.size()) frame_bytes[pos] = v;
  endfunction

  // Lay out a frame of cap_len bytes: random filler with the parsed fields
  // placed where the header lengths put them. Bytes past cap_len are dropped.
  task automatic build_frame(input logic [15:0] etype, input logic [7:0] proto,
                             input logic [3:0] ihl, input logic [3:0] doff,
                             input logic [15:0] total_len, input int prefix_sel,
                             input int cap_len);
    int         tcp_at, pay_at;
    string      pfx;
    logic [3:0] flags;
    frame_bytes.delete();
    repeat (cap_len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    tcp_at = 14 + 4 * ihl;
    pay_at = tcp_at + 4 * doff;
    flags  = 4'($urandom);
    if (prefix_sel < NUM_PREFIX) begin
      pfx = http_prefix(prefix_sel);
      for (int k = 0; k < pfx.len(); k++) put_byte(pay_at + k, pfx[k]);
    end else if (prefix_sel == PFX_NEAR_MISS) begin
      // all but the final character of a real prefix
      pfx = http_prefix($urandom_range(0, NUM_PREFIX - 1));
      for (int k = 0; k < pfx.len() - 1; k++) put_byte(pay_at + k, pfx[k]);
      put_byte(pay_at + pfx.len() - 1, pfx[pfx.len() - 1] ^ 8'h01);
    end
    put_byte(tcp_at + 12, {doff, flags});
    // IP fields go in last so that a short IP header cannot overwrite them
    put_byte(12, etype[15:8]);
    put_byte(13, etype[7:0]);
    put_byte(14, {4'h4, ihl});
    put_byte(16, total_len[15:8]);
    put_byte(17, total_len[7:0]);
    put_byte(23, proto);
  endtask

  task automatic send_built_frame(input logic [15:0] etype, input logic [7:0] proto,
                                  input logic [3:0] ihl, input logic [3:0] doff,
                                  input logic [15:0] total_len, input int prefix_sel,
                                  input int cap_len);
    build_frame(etype, proto, ihl, doff, total_len, prefix_sel, cap_len);
    send_frame(1'b1);
  endtask

  // Write both match registers in consecutive cycles; the block is idle here.
  task automatic apply_match_setting(input logic [15:0] ethertype_val, input logic [7:0] proto_val);
    logic [15:0] proto_word;
    // upper bits are junk; only the low byte may reach the protocol register
    proto_word      = 16'($urandom);
    proto_word[7:0] = proto_val;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ETHERTYPE;
    cfg_wdata <= ethertype_val;
    @(posedge clk);
    match_ethertype_q = ethertype_val;
    cfg_index <= CFG_PROTOCOL;
    cfg_wdata <= proto_word;
    @(posedge clk);
    match_protocol_q = proto_word[7:0];
    cfg_we <= 1'b0;
  endtask

  function automatic logic [3:0] pick_header_words();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 4'd5;
    if (r < 17) return 4'($urandom_range(6, 15));
    return 4'($urandom_range(0, 4));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Boundaries of every status, each prefix, and the field extremes, under
  // the reset values of the match registers.
  task automatic test_directed_frames();
    logic [15:0] et;
    logic [7:0]  pr;
    et = match_ethertype_q;
    pr = match_protocol_q;
    send_built_frame(et, pr, 5, 5, 40, PFX_NONE, 1);         // last mark on the first byte
    send_built_frame(et, pr, 5, 5, 40, PFX_NONE, 13);        // ends inside the ethertype
    send_built_frame(16'h86DD, pr, 5, 5, 40, PFX_NONE, 14);  // foreign ethertype
    send_built_frame(et, pr, 5, 5, 40, PFX_NONE, 23);        // ends before the protocol
    send_built_frame(et, 8'd17, 5, 5, 40, PFX_NONE, 24);     // foreign protocol
    send_built_frame(et, pr, 0, 5, 40, PFX_NONE, 24);        // empty IP header
    send_built_frame(et, pr, 4, 5, 40, PFX_NONE, 24);        // IP header one word short
    send_built_frame(et, pr, 5, 5, 40, PFX_NONE, 46);        // ends before the data offset
    send_built_frame(et, pr, 5, 0, 40, PFX_NONE, 47);        // empty TCP header
    send_built_frame(et, pr, 5, 4, 40, PFX_NONE, 47);        // TCP header one word short
    send_built_frame(et, pr, 5, 5, 39, PFX_NONE, 47);        // total length below headers
    send_built_frame(et, pr, 5, 5, 16'h0000, PFX_NONE, 47);
    send_built_frame(et, pr, 5, 15, 80, PFX_NONE, 93);       // payload start not captured
    send_built_frame(et, pr, 5, 15, 80, PFX_NONE, 94);       // accepted, empty payload
    for (int i = 0; i < NUM_PREFIX; i++)
      send_built_frame(et, pr, 5, 5, 52, i, 62);
    send_built_frame(et, pr, 5, 5, 52, PFX_OPTIONS, 61);     // prefix cut off by the capture
    send_built_frame(et, pr, 5, 5, 43, PFX_GET, 64);         // prefix longer than the payload
    send_built_frame(et, pr, 5, 5, 52, PFX_NEAR_MISS, 66);
    send_built_frame(et, pr, 15, 15, 16'hFFFF, PFX_HTTP, 144);
    send_built_frame(et, pr, 15, 15, 124, PFX_GET, 138);     // prefix ends on the last byte
    frame_bytes.delete();
    repeat (20) frame_bytes.push_back(8'h00);
    send_frame(1'b1);
    frame_bytes.delete();
    repeat (20) frame_bytes.push_back(8'hFF);
    send_frame(1'b1);
    wait_for_results();
  endtask

  // Hold the receiver off for a long stretch while short frames keep coming,
  // so both result slots fill and the input stalls.
  task automatic test_output_backpressure();
    @(negedge clk);
    hold_request = 1'b1;
    @(posedge clk);
    repeat (8) send_built_frame(match_ethertype_q, match_protocol_q, 5, 5, 40, PFX_NONE, 1);
    send_built_frame(match_ethertype_q, match_protocol_q, 5, 5, 50, PFX_HTTP, 64);
    while (hold_request) @(posedge clk);
    wait_for_results();
  endtask

  // Mostly well-formed frames with random content, plus malformed and noise frames.
  task automatic test_random_traffic(input int byte_budget, input int min_frames);
    int          start_bytes, start_frames, r, pay_len, hdr, full, cap, len;
    logic [15:0] etype, total_len;
    logic [7:0]  proto;
    logic [3:0]  ihl, doff;
    start_bytes  = bytes_accepted;
    start_frames = frames_closed;
    while (bytes_accepted - start_bytes < byte_budget ||
           frames_closed - start_frames < min_frames) begin
      if ($urandom_range(0, 99) < 15) begin
        len = $urandom_range(1, 60);
        frame_bytes.delete();
        repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
        send_frame(1'b1);
      end else begin
        etype = 16'($urandom);
        if ($urandom_range(0, 9) != 0) etype = match_ethertype_q;
        proto = 8'($urandom);
        if ($urandom_range(0, 9) != 0) proto = match_protocol_q;
        ihl     = pick_header_words();
        doff    = pick_header_words();
        pay_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 24);
        hdr     = 4 * ihl + 4 * doff;
        full    = 14 + hdr + pay_len;
        r = $urandom_range(0, 99);
        if (r < 85) total_len = 16'(hdr + pay_len);
        else if (r < 95) total_len = 16'($urandom_range(0, hdr));
        else total_len = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 70) cap = full;
        else if (r < 85) cap = full + $urandom_range(1, 6);
        else cap = $urandom_range(1, full);
        send_built_frame(etype, proto, ihl, doff, total_len, $urandom_range(0, PFX_NONE + 1), cap);
      end
    end
    wait_for_results();
  endtask

  // Run traffic under several match settings, extremes first, then back to reset values.
  task automatic test_match_registers();
    logic [15:0] et;
    logic [7:0]  pr;
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: begin
          et = 16'hFFFF;
          pr = 8'hFF;
        end
        1: begin
          et = 16'h0000;
          pr = 8'h00;
        end
        2: begin
          et = 16'($urandom);
          pr = 8'($urandom);
        end
        default: begin
          et = ETHERTYPE_RESET;
          pr = PROTOCOL_RESET;
        end
      endcase
      apply_match_setting(et, pr);
      test_random_traffic(40, 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_frame();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_output_backpressure();
    test_match_registers();
    test_random_traffic(150, 2);

    // final stretch: both sides always ready
    idle_enable = 1'b0;
    test_random_traffic(60, 1);

    if (mismatch_count == 0 && header_results_due.size() == 0) begin
      $display("[eth_ipv4_tcp_http_header_parser_unit] OK");
    end else begin
      $display("[eth_ipv4_tcp_http_header_parser_unit] ERROR");
    end
    $finish;
  end

endmodule
